### hdl/tcr_pkg.sv
// Shared constants and fixed-point helpers for the triple comb reverb.
// No dependencies; imported by the reverb top level.
package tcr_pkg;

  // Delay line lengths and the address widths that follow from them.
  localparam int LONG_LEN  = 4096;
  localparam int MID_LEN   = 3153;
  localparam int SHORT_LEN = 2580;
  localparam int LONG_AW   = $clog2(LONG_LEN);
  localparam int MID_AW    = $clog2(MID_LEN);
  localparam int SHORT_AW  = $clog2(SHORT_LEN);

  localparam int SAMPLE_W = 24;
  localparam int AMOUNT_W = 13;

  // Register map: one register, selected by paddr[2].
  localparam logic REG_AMOUNT = 1'b0;

  // Fixed-point coefficients.
  localparam logic [12:0] AMOUNT_ONE       = 13'd4096;
  localparam logic [12:0] AMOUNT_MIN       = 13'd41;
  localparam logic [12:0] DECAY_BASE_Q13   = 13'd2458;
  localparam logic [12:0] NINE_TENTHS_Q13  = 13'd7373;
  localparam logic [12:0] EIGHT_TENTHS_Q13 = 13'd6554;
  localparam logic [15:0] TWO_THIRDS_Q16   = 16'd43691;
  localparam logic [13:0] UNITY_Q13        = 14'd8192;

  // Round half upward and drop 13 fraction bits.
  function automatic logic signed [26:0] rnd13(input logic signed [39:0] v);
    logic signed [39:0] t;
    t = v + 40'sd4096;
    return t[39:13];
  endfunction

  // Clamp to the 24-bit signed range.
  function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
    logic signed [23:0] r;
    if (v > 40'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -40'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

### hdl/tcr_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and holds while the read enable is low.
module tcr_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/triple_comb_reverb_top.sv
// Top level of the triple comb reverb: three feedback comb delay lines in RAM.
// Depends on tcr_pkg and tcr_ram.
//
//   Port group        Direction   Handshake            Moves
//   sample_in         in          in_valid/in_stall    one dry sample per transfer
//   sample_out        out         out_valid/out_stall  one mixed sample per transfer
//   APB config        in/out      psel/penable         reverb_amount at offset 0
//
// The datapath is a four-stage pipeline (RAM read, products, write-back and
// wet product, output register), and one sample per cycle can be sustained
// while the output is not stalled.
// Reset clears the amount, the positions and the pipeline valids;
// the RAMs are not swept, because each line carries a flag that says whether
// its position has wrapped, and until then every tap reads as zero.
// A stalled output holds the output register; the stages behind it close up
// and the input is stalled only when every stage holds an item.
module triple_comb_reverb_top
  import tcr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  // Configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // Input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  // Output channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] sample_out
);

  // ---------------------------------------------------------------------------
  // Configuration. All gains are derived from the written value at the write
  // itself, so an item may follow the write in the very next cycle.
  // ---------------------------------------------------------------------------
  logic [AMOUNT_W-1:0] amount;
  logic                low;          // amount below the threshold: pass through
  logic [12:0]         g_long;
  logic [12:0]         g_mid;
  logic [12:0]         g_short;
  logic [13:0]         dry;
  logic [11:0]         wet;

  logic                cfg_wr;
  logic [12:0]         amt_clamp;
  logic [12:0]         gl_next;
  logic [25:0]         gm_prod;
  logic [25:0]         gs_prod;
  logic [27:0]         wet_prod;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_AMOUNT);

  always_comb begin
    amt_clamp = (pwdata[12:0] > AMOUNT_ONE) ? AMOUNT_ONE : pwdata[12:0];
    gl_next   = DECAY_BASE_Q13 + amt_clamp;
    gm_prod   = 26'(gl_next) * 26'(NINE_TENTHS_Q13) + 26'd4096;
    gs_prod   = 26'(gl_next) * 26'(EIGHT_TENTHS_Q13) + 26'd4096;
    wet_prod  = 28'(amt_clamp) * 28'(TWO_THIRDS_Q16) + 28'd32768;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      amount <= '0;
      low    <= 1'b1;
    end else if (cfg_wr) begin
      amount <= pwdata[AMOUNT_W-1:0];
      low    <= amt_clamp < AMOUNT_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_wr) begin
      g_long  <= gl_next;
      g_mid   <= gm_prod[25:13];
      g_short <= gs_prod[25:13];
      dry     <= UNITY_Q13 - 14'(amt_clamp);
      wet     <= wet_prod[27:16];
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_AMOUNT: prdata = {{(32 - AMOUNT_W){1'b0}}, amount};
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control. Each stage loads when it is empty or when the
  // stage ahead of it loads this cycle.
  // ---------------------------------------------------------------------------
  logic s1_valid, s2_valid, s3_valid;
  logic mv3, mv2, mv1, accept;

  assign mv3      = !s3_valid || !out_valid || !out_stall;
  assign mv2      = !s2_valid || mv3;
  assign mv1      = !s1_valid || mv2;
  assign in_stall = !mv1;
  assign accept   = in_valid && mv1;

  // ---------------------------------------------------------------------------
  // Write positions and wrap flags. Positions only move forward from zero, so
  // an entry at or beyond the position has never been written until the line
  // wraps once; the tap read from it is then forced to zero by the wrap flag.
  // ---------------------------------------------------------------------------
  logic [LONG_AW-1:0]  pos_l;
  logic [MID_AW-1:0]   pos_m;
  logic [SHORT_AW-1:0] pos_s;
  logic                full_l, full_m, full_s;
  logic                advance;

  assign advance = accept && !low;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_l  <= '0;
      pos_m  <= '0;
      pos_s  <= '0;
      full_l <= 1'b0;
      full_m <= 1'b0;
      full_s <= 1'b0;
    end else if (advance) begin
      if (pos_l == LONG_AW'(LONG_LEN - 1)) begin
        pos_l  <= '0;
        full_l <= 1'b1;
      end else begin
        pos_l <= pos_l + 1'b1;
      end
      if (pos_m == MID_AW'(MID_LEN - 1)) begin
        pos_m  <= '0;
        full_m <= 1'b1;
      end else begin
        pos_m <= pos_m + 1'b1;
      end
      if (pos_s == SHORT_AW'(SHORT_LEN - 1)) begin
        pos_s  <= '0;
        full_s <= 1'b1;
      end else begin
        pos_s <= pos_s + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Delay line RAMs. The read is issued on the input transfer; the write-back
  // to the same entry is made from stage 2. At most four items are in
  // flight and every line holds at least ten entries, so a read never meets a
  // pending write to its own entry.
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] rd_l, rd_m, rd_s;
  logic signed [SAMPLE_W-1:0] wr_l, wr_m, wr_s;
  logic                wr_en;
  logic [LONG_AW-1:0]  s2_pl;
  logic [MID_AW-1:0]   s2_pm;
  logic [SHORT_AW-1:0] s2_ps;
  logic                s2_byp;

  assign wr_en = s2_valid && !s2_byp && mv3;

  tcr_ram #(.DEPTH(LONG_LEN), .WIDTH(SAMPLE_W)) u_long_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s2_pl),
    .wdata (wr_l),
    .re    (accept),
    .raddr (pos_l),
    .rdata (rd_l)
  );

  tcr_ram #(.DEPTH(MID_LEN), .WIDTH(SAMPLE_W)) u_mid_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s2_pm),
    .wdata (wr_m),
    .re    (accept),
    .raddr (pos_m),
    .rdata (rd_m)
  );

  tcr_ram #(.DEPTH(SHORT_LEN), .WIDTH(SAMPLE_W)) u_short_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s2_ps),
    .wdata (wr_s),
    .re    (accept),
    .raddr (pos_s),
    .rdata (rd_s)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: the sample, its positions and the wrap flags, alongside the RAM
  // read data.
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] s1_x;
  logic [LONG_AW-1:0]         s1_pl;
  logic [MID_AW-1:0]          s1_pm;
  logic [SHORT_AW-1:0]        s1_ps;
  logic                       s1_byp, s1_live_l, s1_live_m, s1_live_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (mv1) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x      <= sample_in;
      s1_pl     <= pos_l;
      s1_pm     <= pos_m;
      s1_ps     <= pos_s;
      s1_byp    <= low;
      s1_live_l <= full_l;
      s1_live_m <= full_m;
      s1_live_s <= full_s;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: feedback products, the tap sum and the dry product.
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] tap_l, tap_m, tap_s;
  logic signed [SAMPLE_W-1:0] s2_x;
  logic signed [37:0]         s2_prod_l, s2_prod_m, s2_prod_s;
  logic signed [25:0]         s2_tsum;
  logic signed [38:0]         s2_xdry;

  always_comb begin
    tap_l = s1_live_l ? $signed(rd_l) : '0;
    tap_m = s1_live_m ? $signed(rd_m) : '0;
    tap_s = s1_live_s ? $signed(rd_s) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (mv2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mv2) begin
      s2_x      <= s1_x;
      s2_pl     <= s1_pl;
      s2_pm     <= s1_pm;
      s2_ps     <= s1_ps;
      s2_byp    <= s1_byp;
      s2_prod_l <= tap_l * $signed({1'b0, g_long});
      s2_prod_m <= tap_m * $signed({1'b0, g_mid});
      s2_prod_s <= tap_s * $signed({1'b0, g_short});
      s2_tsum   <= 26'(tap_l) + 26'(tap_m) + 26'(tap_s);
      s2_xdry   <= s1_x * $signed({1'b0, dry});
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: write-back values go to the RAMs; the wet product is formed.
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] s3_x;
  logic signed [38:0]         s3_xdry;
  logic signed [38:0]         s3_tw;
  logic                       s3_byp;

  always_comb begin
    wr_l = sat24(40'(s2_x) + 40'(rnd13(40'(s2_prod_l))));
    wr_m = sat24(40'(s2_x) + 40'(rnd13(40'(s2_prod_m))));
    wr_s = sat24(40'(s2_x) + 40'(rnd13(40'(s2_prod_s))));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (mv3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mv3) begin
      s3_x    <= s2_x;
      s3_byp  <= s2_byp;
      s3_xdry <= s2_xdry;
      s3_tw   <= s2_tsum * $signed({1'b0, wet});
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: dry plus wet, rounded and saturated, or the sample itself
  // when the amount is too small to matter.
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] mix;

  always_comb begin
    mix = sat24(40'(rnd13(40'(s3_xdry) + 40'(s3_tw))));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      sample_out <= s3_byp ? s3_x : mix;
    end
  end

endmodule
